/* rtl/eft_pkg.sv */
// Shared types and codes for the expiring flag table.
package eft_pkg;

  localparam logic [1:0] MODE_SET      = 2'd0;
  localparam logic [1:0] MODE_UNSET    = 2'd1;
  localparam logic [1:0] MODE_ISSET    = 2'd2;
  localparam logic [1:0] MODE_ISNOTSET = 2'd3;

  localparam int unsigned EntryW = 128;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] track_hash;
    logic [31:0] name_hash;
    logic [31:0] expire_seconds;
    logic [31:0] now_time;
    logic [31:0] signature_id;
    logic        last_check;
    logic [3:0]  want_isset;
    logic [3:0]  want_isnotset;
  } in_item_t;

  typedef struct packed {
    logic found_live;
    logic condition_valid;
    logic condition_met;
    logic table_full;
  } out_item_t;

  typedef struct packed {
    logic [31:0] track_hash;
    logic [31:0] name_hash;
    logic [31:0] expiry;
    logic [31:0] signature;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic start;
    logic issue;
    logic finish;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_end;
    logic out_free;
  } ctl_sts_t;

endpackage

/* rtl/eft_ram.sv */
// Generic simple dual-port RAM, one write and one registered read per cycle.
module eft_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/eft_ctrl.sv */
// Controller: accept, scan and finish sequencing for one item at a time.
module eft_ctrl import eft_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ctl_sts_t sts_i,
  output ctl_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // last read still in flight is resolved during this cycle
        if (sts_i.scan_end) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.issue = 1'b1;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/eft_dp.sv */
// Datapath: entry store, scan compare, count, tallies and result register.
module eft_dp import eft_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned TALLY_MAX   = 15
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  ctl_cmd_t  cmd_i,
  output ctl_sts_t  sts_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned TW   = $clog2(TALLY_MAX + 1);
  localparam int unsigned CmpW = 8;

  in_item_t    item_q;
  logic [31:0] exp_q;
  logic [32:0] exp_sum;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] rd_idx_q;
  logic          rd_vld_q;
  logic          found_q, found_d;
  logic [TW-1:0] isset_q, isset_d, notset_q, notset_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_item_q;

  entry_t        rd_entry, wr_entry;
  logic [EntryW-1:0] rd_word;
  logic          we;
  logic [AW-1:0] waddr;
  logic          hit, live;
  logic          is_upd, need_new, has_room;

  eft_ram #(
    .WIDTH (EntryW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.issue),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rd_word)
  );

  assign rd_entry = entry_t'(rd_word);
  assign exp_sum  = {1'b0, in_item_i.now_time} + {1'b0, in_item_i.expire_seconds};

  assign is_upd   = (item_q.mode == MODE_SET) || (item_q.mode == MODE_UNSET);
  assign hit      = (rd_entry.track_hash == item_q.track_hash)
                 && (rd_entry.name_hash == item_q.name_hash);
  assign live     = hit && (rd_entry.expiry != '0) && (item_q.now_time < rd_entry.expiry);
  assign has_room = (count_q != CW'(TABLE_DEPTH));
  assign need_new = (item_q.mode == MODE_SET) && !found_q;

  assign sts_o.scan_end = (idx_q == count_q);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // entry write: refresh/clear a match during the scan, append at finish
  always_comb begin
    we       = 1'b0;
    waddr    = rd_idx_q;
    wr_entry = rd_entry;
    if (rd_vld_q && is_upd && hit) begin
      we = 1'b1;
      if (item_q.mode == MODE_SET) begin
        wr_entry.expiry    = exp_q;
        wr_entry.signature = item_q.signature_id;
      end else begin
        wr_entry.expiry = '0;
      end
    end else if (cmd_i.finish && need_new && has_room) begin
      we                  = 1'b1;
      waddr               = count_q[AW-1:0];
      wr_entry.track_hash = item_q.track_hash;
      wr_entry.name_hash  = item_q.name_hash;
      wr_entry.expiry     = exp_q;
      wr_entry.signature  = item_q.signature_id;
    end
  end

  always_comb begin
    idx_d       = idx_q;
    found_d     = found_q;
    count_d     = count_q;
    isset_d     = isset_q;
    notset_d    = notset_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.start) begin
      idx_d   = '0;
      found_d = 1'b0;
    end
    if (cmd_i.issue) begin
      idx_d = idx_q + CW'(1);
    end
    if (rd_vld_q) begin
      found_d = found_q | (is_upd ? hit : live);
    end
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
      if (need_new && has_room) begin
        count_d = count_q + CW'(1);
      end
      if ((item_q.mode == MODE_ISSET) && found_q && (isset_q != TW'(TALLY_MAX))) begin
        isset_d = isset_q + TW'(1);
      end
      if ((item_q.mode == MODE_ISNOTSET) && !found_q && (notset_q != TW'(TALLY_MAX))) begin
        notset_d = notset_q + TW'(1);
      end
      if (item_q.last_check) begin
        isset_d  = '0;
        notset_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      count_q     <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      isset_q     <= '0;
      notset_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      count_q     <= count_d;
      rd_vld_q    <= cmd_i.issue;
      found_q     <= found_d;
      isset_q     <= isset_d;
      notset_q    <= notset_d;
      out_valid_q <= out_valid_d;
    end
  end

  // tallies after this item's own query, before the clear
  function automatic logic [TW-1:0] isset_d_pre(input logic [TW-1:0] t);
    logic [TW-1:0] r;
    r = t;
    if ((item_q.mode == MODE_ISSET) && found_q && (t != TW'(TALLY_MAX))) begin
      r = t + TW'(1);
    end
    return r;
  endfunction

  function automatic logic [TW-1:0] notset_pre(input logic [TW-1:0] t);
    logic [TW-1:0] r;
    r = t;
    if ((item_q.mode == MODE_ISNOTSET) && !found_q && (t != TW'(TALLY_MAX))) begin
      r = t + TW'(1);
    end
    return r;
  endfunction

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      item_q <= in_item_i;
      exp_q  <= exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
    end
    if (cmd_i.issue) begin
      rd_idx_q <= idx_q[AW-1:0];
    end
    if (cmd_i.finish) begin
      out_item_q.found_live      <= found_q;
      out_item_q.condition_valid <= item_q.last_check;
      out_item_q.condition_met   <= item_q.last_check
          && (CmpW'(isset_d_pre(isset_q)) == CmpW'(item_q.want_isset))
          && (CmpW'(notset_pre(notset_q)) == CmpW'(item_q.want_isnotset));
      out_item_q.table_full      <= need_new && !has_room;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* rtl/expiring_flag_table_core.sv */
// Each accepted beat scans the N stored entries (N = 0..TABLE_DEPTH), then writes its result register.
// A new item is taken only once the last one has finished; the scan reads one entry per cycle from one RAM port.
// The next item is taken while a finished result waits in the output register.
// Reset (async, active low) clears entry count, tallies and handshake state;
// entry storage is not cleared, only entries below the count are ever read.
module expiring_flag_table_core import eft_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned TALLY_MAX   = 15
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  eft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  eft_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TALLY_MAX   (TALLY_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* dv/tb.sv */
// Testbench for expiring_flag_table_core: directed and random flag traffic checked in order.
`timescale 1ns / 1ps

module tb;
  import eft_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 256;
  localparam int unsigned TALLY_MAX    = 15;
  localparam int          LIMIT_CYCLES = 1_000_000;
  localparam int          HOLD_CYCLES  = 800;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  expiring_flag_table_core #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .TALLY_MAX  (TALLY_MAX)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the flag table
  logic [31:0] tbl_track  [TABLE_DEPTH];
  logic [31:0] tbl_name   [TABLE_DEPTH];
  logic [31:0] tbl_expiry [TABLE_DEPTH];
  logic [31:0] tbl_sig    [TABLE_DEPTH];
  int          tbl_count = 0;
  int          set_tally = 0;
  int          notset_tally = 0;

  out_item_t   expected_q[$];

  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  bit          sink_hold = 1'b0;
  int          cycle_count = 0;
  int          mismatches = 0;
  int          items_accepted = 0;
  int          results_checked = 0;
  int          full_seen = 0;
  int          verdicts_seen = 0;
  int          met_seen = 0;
  int          live_seen = 0;

  logic [31:0] track_keys [4];
  logic [31:0] name_keys  [3];
  logic [31:0] wall_clock = 32'd1000;

  function automatic int tally_bump(int t);
    return (t < TALLY_MAX) ? t + 1 : TALLY_MAX;
  endfunction

  // Applies one beat to the shadow table and returns the result it must produce.
  function automatic out_item_t flag_table_step(in_item_t it);
    out_item_t   r;
    logic [32:0] sum;
    logic [31:0] expiry;
    bit          hit;
    r   = '0;
    hit = 1'b0;
    if (it.mode == MODE_SET || it.mode == MODE_UNSET) begin
      sum    = {1'b0, it.now_time} + {1'b0, it.expire_seconds};
      expiry = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_track[i] == it.track_hash && tbl_name[i] == it.name_hash) begin
          hit = 1'b1;
          if (it.mode == MODE_SET) begin
            tbl_expiry[i] = expiry;
            tbl_sig[i]    = it.signature_id;
          end else begin
            tbl_expiry[i] = '0;
          end
        end
      end
      if (it.mode == MODE_SET && !hit) begin
        if (tbl_count < TABLE_DEPTH) begin
          tbl_track[tbl_count]  = it.track_hash;
          tbl_name[tbl_count]   = it.name_hash;
          tbl_expiry[tbl_count] = expiry;
          tbl_sig[tbl_count]    = it.signature_id;
          tbl_count++;
        end else begin
          r.table_full = 1'b1;
        end
      end
    end else begin
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_track[i] == it.track_hash && tbl_name[i] == it.name_hash &&
            tbl_expiry[i] != '0 && it.now_time < tbl_expiry[i])
          hit = 1'b1;
      end
      if (it.mode == MODE_ISSET) begin
        if (hit) set_tally = tally_bump(set_tally);
      end else if (!hit) begin
        notset_tally = tally_bump(notset_tally);
      end
    end
    r.found_live = hit;
    // own query is tallied before the compare
    if (it.last_check) begin
      r.condition_valid = 1'b1;
      r.condition_met   = (set_tally == it.want_isset) && (notset_tally == it.want_isnotset);
      set_tally    = 0;
      notset_tally = 0;
    end
    return r;
  endfunction

  // input monitor: predict on every accepted beat
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_q.push_back(flag_table_step(in_item_i));
      items_accepted++;
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (out_item_o.table_full) full_seen++;
      if (out_item_o.condition_valid) verdicts_seen++;
      if (out_item_o.condition_met) met_seen++;
      if (out_item_o.found_live) live_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH at %0t: result beat with nothing pending, got %p", $realtime,
                   out_item_o);
      end else begin
        want = expected_q.pop_front();
        if (out_item_o.found_live !== want.found_live ||
            out_item_o.condition_valid !== want.condition_valid ||
            out_item_o.condition_met !== want.condition_met ||
            out_item_o.table_full !== want.table_full) begin
          mismatches++;
          if (mismatches <= 10)
            $display("MISMATCH at %0t: exp fvmt=%b%b%b%b got fvmt=%b%b%b%b",
                     $realtime, want.found_live, want.condition_valid, want.condition_met,
                     want.table_full, out_item_o.found_live, out_item_o.condition_valid,
                     out_item_o.condition_met, out_item_o.table_full);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= sink_hold || ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", LIMIT_CYCLES, expected_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_flag_item(in_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic in_item_t flag_item(logic [1:0] mode, logic [31:0] th, logic [31:0] nh,
                                         logic [31:0] dur, logic [31:0] now, logic last,
                                         logic [3:0] want_set, logic [3:0] want_notset);
    in_item_t it;
    it.mode           = mode;
    it.track_hash     = th;
    it.name_hash      = nh;
    it.expire_seconds = dur;
    it.now_time       = now;
    it.signature_id   = $urandom;
    it.last_check     = last;
    it.want_isset     = want_set;
    it.want_isnotset  = want_notset;
    return it;
  endfunction

  function automatic in_item_t random_flag_item();
    in_item_t it;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 35) it.mode = MODE_SET;
    else if (pick < 47) it.mode = MODE_UNSET;
    else if (pick < 74) it.mode = MODE_ISSET;
    else it.mode = MODE_ISNOTSET;
    if ($urandom_range(99) < 8) begin
      it.track_hash = $urandom;
      it.name_hash  = $urandom;
    end else begin
      it.track_hash = track_keys[$urandom_range(3)];
      it.name_hash  = name_keys[$urandom_range(2)];
    end
    pick = $urandom_range(99);
    if (pick < 85) begin
      wall_clock  = wall_clock + $urandom_range(2);
      it.now_time = wall_clock;
    end else if (pick < 93) begin
      it.now_time = 32'hFFFF_FFFF - $urandom_range(20);
    end else begin
      it.now_time = $urandom;
    end
    it.expire_seconds = ($urandom_range(99) < 70) ? 32'($urandom_range(60)) : 32'($urandom);
    it.signature_id   = $urandom;
    it.last_check     = ($urandom_range(99) < 25);
    // half the time aim the wanted counts at the running tallies
    if ($urandom_range(1)) begin
      it.want_isset    = 4'(set_tally + $urandom_range(1));
      it.want_isnotset = 4'(notset_tally + $urandom_range(1));
    end else begin
      it.want_isset    = 4'($urandom_range(15));
      it.want_isnotset = 4'($urandom_range(15));
    end
    return it;
  endfunction

  task automatic test_directed();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    // empty table, then verdict on a query
    send_flag_item(flag_item(MODE_ISNOTSET, '0, '0, '0, '0, 1'b0, 4'd0, 4'd0));
    send_flag_item(flag_item(MODE_ISSET, '0, '0, '0, '0, 1'b1, 4'd0, 4'd1));
    // zero expiry never lives; verdict on a set
    send_flag_item(flag_item(MODE_SET, '0, '0, '0, '0, 1'b1, 4'd0, 4'd0));
    send_flag_item(flag_item(MODE_SET, '0, '0, 32'd50, 32'd100, 1'b0, 4'd0, 4'd0));
    send_flag_item(flag_item(MODE_ISSET, '0, '0, '0, 32'd149, 1'b0, 4'd0, 4'd0));
    // expiry boundary: now equal to expiry is dead
    send_flag_item(flag_item(MODE_ISNOTSET, '0, '0, '0, 32'd150, 1'b1, 4'd1, 4'd1));
    // saturating expiry
    send_flag_item(flag_item(MODE_SET, '1, '1, '1, 32'hFFFF_FFF0, 1'b0, 4'd0, 4'd0));
    send_flag_item(flag_item(MODE_ISSET, '1, '1, '0, 32'hFFFF_FFFE, 1'b0, 4'd0, 4'd0));
    // one hash matches, the other does not
    send_flag_item(flag_item(MODE_ISSET, '0, '1, '0, 32'd120, 1'b0, 4'd0, 4'd0));
    // unset with verdict; unset of a missing key
    send_flag_item(flag_item(MODE_UNSET, '0, '0, '1, 32'd120, 1'b1, 4'd0, 4'd0));
    send_flag_item(flag_item(MODE_UNSET, '1, '0, '0, 32'd120, 1'b0, 4'd15, 4'd15));
    send_flag_item(flag_item(MODE_ISNOTSET, '1, '1, '0, '1, 1'b0, 4'd0, 4'd0));
    // isset tally saturates
    for (int k = 0; k < 16; k++)
      send_flag_item(flag_item(MODE_ISSET, '1, '1, '0, 32'hFFFF_FFFE, k == 15, 4'd15, 4'd1));
  endtask

  task automatic test_random_traffic();
    int idle_pcts  [4] = '{0, 48, 0, 15};
    int stall_pcts [4] = '{0, 0, 48, 15};
    track_keys[0] = '0;
    track_keys[1] = '1;
    track_keys[2] = $urandom;
    track_keys[3] = $urandom;
    name_keys[0]  = '1;
    name_keys[1]  = $urandom;
    name_keys[2]  = $urandom;
    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = idle_pcts[p];
      sink_stall_pct = stall_pcts[p];
      repeat (40) send_flag_item(random_flag_item());
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    fork
      begin
        @(posedge clk_i);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        sink_hold = 1'b0;
      end
      repeat (30) send_flag_item(random_flag_item());
    join
  endtask

  task automatic test_table_full();
    src_idle_pct   = 15;
    sink_stall_pct = 15;
    while (tbl_count < TABLE_DEPTH)
      send_flag_item(flag_item(MODE_SET, $urandom, $urandom, $urandom_range(500), wall_clock,
                               1'($urandom_range(1)), 4'd0, 4'd0));
    repeat (4)
      send_flag_item(flag_item(MODE_SET, $urandom, $urandom, 32'd10, wall_clock,
                               1'($urandom_range(1)), 4'd0, 4'd0));
    // refresh of a stored key still works when full
    send_flag_item(flag_item(MODE_SET, track_keys[0], name_keys[0], 32'd100, wall_clock,
                             1'b0, 4'd0, 4'd0));
    send_flag_item(flag_item(MODE_ISSET, track_keys[0], name_keys[0], '0, wall_clock + 1,
                             1'b1, 4'd1, 4'd0));
    repeat (6) send_flag_item(random_flag_item());
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_traffic();
    test_backpressure();
    test_table_full();
    in_valid_i <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);
    $display("run covered %0d beats in, %0d results checked, table holding %0d of %0d entries",
             items_accepted, results_checked, tbl_count, TABLE_DEPTH);
    $display("verdicts %0d (met %0d), table-full refusals %0d, live hits %0d, %0d cycles",
             verdicts_seen, met_seen, full_seen, live_seen, cycle_count);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatches, expected_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
